>>> design/drc_pkg.sv
// shared types and constants of the dirty rectangle coalescer
`default_nettype none

package drc_pkg;

    // default sizing of the rectangle table and minimum rectangle edge
    localparam int DRC_MAX_RECTS     = 32;
    localparam int DRC_MIN_RECT_SIZE = 32;

    // field widths, areas sized for the full 15-bit texture range
    localparam int IN_W       = 16;
    localparam int COORD_W    = 15;
    localparam int AREA_W     = 30;
    localparam int SUM_W      = AREA_W + 1;
    localparam int CMP_W      = 36;
    localparam int CFG_W      = 15;
    localparam int CFG_ADDR_W = 1;

    // merge ratio: union area times MERGE_DEN against area sum times MERGE_NUM
    localparam int MERGE_NUM = 23;
    localparam int MERGE_DEN = 20;

    // register reset values
    localparam logic [CFG_W-1:0] TEX_WIDTH_RESET  = 15'd1920;
    localparam logic [CFG_W-1:0] TEX_HEIGHT_RESET = 15'd1080;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } cfg_reg_t;

    // rectangle with inclusive low and exclusive high edges
    typedef struct packed {
        logic [COORD_W-1:0] l;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] b;
    } rect_t;

    // one table entry: rectangle plus its area
    typedef struct packed {
        rect_t              rect;
        logic [AREA_W-1:0]  area;
    } entry_t;

    // candidate rectangle travelling down the cell row
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } token_t;

    // control from the sequencer to one cell
    typedef struct packed {
        logic occupied;
        logic force_merge;
        logic shift;
    } cell_ctrl_t;

    // status from one cell to the sequencer
    typedef struct packed {
        logic hit;
        logic append;
    } cell_stat_t;

endpackage

`default_nettype wire

>>> design/drc_ifs.sv
// valid/ready channel interfaces for dirty rectangles in and merged rectangles out
`default_nettype none

interface drc_in_if;
    logic                       valid;
    logic                       ready;
    logic [drc_pkg::IN_W-1:0]   rect_x;
    logic [drc_pkg::IN_W-1:0]   rect_y;
    logic [drc_pkg::IN_W-1:0]   rect_w;
    logic [drc_pkg::IN_W-1:0]   rect_h;
    logic                       frame_end;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, frame_end, input ready);
    modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, frame_end, output ready);
endinterface

interface drc_out_if;
    logic                           valid;
    logic                           ready;
    logic [drc_pkg::COORD_W-1:0]    left;
    logic [drc_pkg::COORD_W-1:0]    top;
    logic [drc_pkg::COORD_W-1:0]    right;
    logic [drc_pkg::COORD_W-1:0]    bottom;
    logic                           last_out;

    modport source (output valid, left, top, right, bottom, last_out, input ready);
    modport sink   (input valid, left, top, right, bottom, last_out, output ready);
endinterface

`default_nettype wire

>>> design/drc_cell.sv
// one table cell: holds an entry, tests the passing candidate and merges or appends it
`default_nettype none

module drc_cell
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire drc_pkg::cell_ctrl_t ctrl,
    input  wire drc_pkg::token_t tok_in,
    output drc_pkg::token_t      tok_out,
    input  wire drc_pkg::entry_t shift_in,
    output drc_pkg::entry_t      entry_out,
    output drc_pkg::cell_stat_t  stat
);
    import drc_pkg::*;

    entry_t               entry_reg;
    logic                 a_valid_reg;
    entry_t               a_tok_reg;
    rect_t                u_rect_reg;
    logic [AREA_W-1:0]    u_area_reg;

    rect_t                u_rect;
    logic [2*COORD_W-1:0] u_prod;
    logic [SUM_W-1:0]     area_sum;
    logic [CMP_W-1:0]     lhs;
    logic [CMP_W-1:0]     rhs;
    logic                 merge_ok;
    logic                 hit;

    // union of the stored entry with the incoming candidate
    always_comb
    begin
        u_rect.l = (entry_reg.rect.l < tok_in.ent.rect.l) ? entry_reg.rect.l : tok_in.ent.rect.l;
        u_rect.t = (entry_reg.rect.t < tok_in.ent.rect.t) ? entry_reg.rect.t : tok_in.ent.rect.t;
        u_rect.r = (entry_reg.rect.r > tok_in.ent.rect.r) ? entry_reg.rect.r : tok_in.ent.rect.r;
        u_rect.b = (entry_reg.rect.b > tok_in.ent.rect.b) ? entry_reg.rect.b : tok_in.ent.rect.b;
        u_prod   = (2*COORD_W)'(u_rect.r - u_rect.l) * (2*COORD_W)'(u_rect.b - u_rect.t);
    end

    // first stage: latch candidate, union and union area
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tok_reg  <= tok_in.ent;
        u_rect_reg <= u_rect;
        u_area_reg <= u_prod[AREA_W-1:0];
    end

    // second stage: ratio test against the area sum
    always_comb
    begin
        area_sum = SUM_W'(entry_reg.area) + SUM_W'(a_tok_reg.area);
        lhs      = CMP_W'(MERGE_DEN) * CMP_W'(u_area_reg);
        rhs      = CMP_W'(MERGE_NUM) * CMP_W'(area_sum);
        merge_ok = (lhs <= rhs);
        hit      = a_valid_reg && (!ctrl.occupied || merge_ok || ctrl.force_merge);
    end

    // entry update: merge, append, or shift toward the output during emission
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            if (ctrl.occupied)
            begin
                entry_reg.rect <= u_rect_reg;
                entry_reg.area <= u_area_reg;
            end
            else
            begin
                entry_reg <= a_tok_reg;
            end
        end
        else if (ctrl.shift)
        begin
            entry_reg <= shift_in;
        end
    end

    // candidate moves on only when this cell did not take it
    assign tok_out.valid = a_valid_reg && !hit;
    assign tok_out.ent   = a_tok_reg;
    assign entry_out     = entry_reg;
    assign stat.hit      = hit;
    assign stat.append   = hit && !ctrl.occupied;

endmodule

`default_nettype wire

>>> design/dirty_rect_coalescer.sv
// top level: clamps and grows dirty rectangles, coalesces them in a cell row, emits per frame
//
// Usage:
//  - dirty (sink): one rectangle per word, rect_x/rect_y/rect_w/rect_h and frame_end.
//    Each rectangle is clamped to tex_width x tex_height, dropped when empty, grown to
//    MIN_RECT_SIZE per axis and merged into the first stored rectangle that passes the
//    23/20 area test, else appended; a full table merges into its last entry.
//  - merged (source): on a word with frame_end set, the stored rectangles leave in table
//    order, one word per cycle while the receiver is ready; last_out marks the final one.
//  - cfg_we/cfg_addr/cfg_wdata: writes tex_width (index 0) and tex_height (index 1),
//    to be done only while the block is idle.
// Flow: a word is accepted, clamped, grown, given its area and injected into the first
// cell; the candidate then walks the cell row one cell per cycle to the cell j that
// takes it (j at most MAX_RECTS - 1), and the next word is accepted right after. An
// empty rectangle is dropped after the clamp. The last merged word sits in the output
// register while the next dirty word is accepted. A stalled receiver holds emission;
// the table shifts only when a word is moved into the output register. Reset empties
// the table and restores 1920 x 1080.
`default_nettype none

module dirty_rect_coalescer
#(
    parameter int MAX_RECTS     = drc_pkg::DRC_MAX_RECTS,
    parameter int MIN_RECT_SIZE = drc_pkg::DRC_MIN_RECT_SIZE
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [drc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [drc_pkg::CFG_W-1:0]        cfg_wdata,
    drc_in_if.sink                           dirty,
    drc_out_if.source                        merged
);
    import drc_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_GROW,
        S_AREA,
        S_INJECT,
        S_WALK,
        S_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CFG_W-1:0]     tex_w_reg;
    logic [CFG_W-1:0]     tex_h_reg;
    logic [IN_W-1:0]      rx_reg;
    logic [IN_W-1:0]      ry_reg;
    logic [IN_W-1:0]      rw_reg;
    logic [IN_W-1:0]      rh_reg;
    logic                 last_reg;
    rect_t                cand_reg;
    logic [AREA_W-1:0]    area_reg;
    rect_t                out_rect_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    rect_t                clamped;
    logic                 clamp_empty;
    rect_t                grown;
    logic [2*COORD_W-1:0] cand_prod;
    logic                 emit_fire;
    logic                 any_hit;
    logic                 any_append;

    token_t               tok  [MAX_RECTS+1];
    entry_t               ent  [MAX_RECTS+1];
    cell_ctrl_t           cctl [MAX_RECTS];
    cell_stat_t           stat [MAX_RECTS];
    logic [MAX_RECTS-1:0] hit_vec;
    logic [MAX_RECTS-1:0] app_vec;

    // clamp an edge to the texture size
    function automatic logic [COORD_W-1:0] clamp_pos(logic [IN_W-1:0] v, logic [CFG_W-1:0] lim);
        logic [COORD_W-1:0] res;
        res = (v > IN_W'(lim)) ? lim : v[COORD_W-1:0];
        return res;
    endfunction

    // grow low edge outward by half the missing size
    function automatic logic [COORD_W-1:0] grow_lo(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
        logic [COORD_W:0] size;
        logic [COORD_W:0] extra;
        logic [COORD_W:0] half;
        logic [COORD_W-1:0] res;
        size  = (COORD_W+1)'(hi - lo);
        extra = (size < (COORD_W+1)'(MIN_RECT_SIZE)) ? (COORD_W+1)'(MIN_RECT_SIZE) - size : '0;
        half  = extra >> 1;
        res   = ((COORD_W+1)'(lo) >= half) ? lo - half[COORD_W-1:0] : '0;
        return res;
    endfunction

    // grow high edge outward by the rest of the missing size
    function automatic logic [COORD_W-1:0] grow_hi(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi,
                                                   logic [CFG_W-1:0] lim);
        logic [COORD_W:0] size;
        logic [COORD_W:0] extra;
        logic [COORD_W:0] rest;
        logic [COORD_W:0] sum;
        logic [COORD_W-1:0] res;
        size  = (COORD_W+1)'(hi - lo);
        extra = (size < (COORD_W+1)'(MIN_RECT_SIZE)) ? (COORD_W+1)'(MIN_RECT_SIZE) - size : '0;
        rest  = extra - (extra >> 1);
        sum   = (COORD_W+1)'(hi) + rest;
        res   = (sum > (COORD_W+1)'(lim)) ? lim : sum[COORD_W-1:0];
        return res;
    endfunction

    // clamp of the accepted rectangle and growth of the clamped one
    always_comb
    begin
        clamped.l   = clamp_pos(rx_reg, tex_w_reg);
        clamped.t   = clamp_pos(ry_reg, tex_h_reg);
        clamped.r   = clamped.l + clamp_pos(rw_reg, tex_w_reg - clamped.l);
        clamped.b   = clamped.t + clamp_pos(rh_reg, tex_h_reg - clamped.t);
        clamp_empty = (clamped.r == clamped.l) || (clamped.b == clamped.t);
        grown.l     = grow_lo(cand_reg.l, cand_reg.r);
        grown.r     = grow_hi(cand_reg.l, cand_reg.r, tex_w_reg);
        grown.t     = grow_lo(cand_reg.t, cand_reg.b);
        grown.b     = grow_hi(cand_reg.t, cand_reg.b, tex_h_reg);
        cand_prod   = (2*COORD_W)'(cand_reg.r - cand_reg.l) * (2*COORD_W)'(cand_reg.b - cand_reg.t);
    end

    // candidate enters the first cell for one cycle
    assign tok[0].valid    = (state_reg == S_INJECT);
    assign tok[0].ent.rect = cand_reg;
    assign tok[0].ent.area = area_reg;
    assign ent[MAX_RECTS]  = '0;

    // row of table cells
    for (genvar i = 0; i < MAX_RECTS; i++)
    begin : g_cell
        assign cctl[i].occupied    = (CNT_W'(i) < count_reg);
        assign cctl[i].force_merge = (i == MAX_RECTS - 1);
        assign cctl[i].shift       = emit_fire;

        drc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cctl[i]),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1]),
            .shift_in  (ent[i+1]),
            .entry_out (ent[i]),
            .stat      (stat[i])
        );

        assign hit_vec[i] = stat[i].hit;
        assign app_vec[i] = stat[i].append;
    end

    assign any_hit    = |hit_vec;
    assign any_append = |app_vec;
    assign emit_fire  = (state_reg == S_EMIT) && (count_reg != '0)
                        && (!out_valid_reg || merged.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (dirty.valid)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (clamp_empty)
                begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:   state_next = S_AREA;
            S_AREA:   state_next = S_INJECT;
            S_INJECT: state_next = S_WALK;
            S_WALK:
            begin
                if (any_hit)
                begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state, configuration, candidate, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tex_w_reg     <= TEX_WIDTH_RESET;
            tex_h_reg     <= TEX_HEIGHT_RESET;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_rect_reg  <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            rw_reg        <= '0;
            rh_reg        <= '0;
            cand_reg      <= '0;
            area_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_TEX_WIDTH:  tex_w_reg <= cfg_wdata;
                    REG_TEX_HEIGHT: tex_h_reg <= cfg_wdata;
                    default:        tex_w_reg <= tex_w_reg;
                endcase
            end

            // accept a dirty word
            if (state_reg == S_IDLE && dirty.valid)
            begin
                rx_reg   <= dirty.rect_x;
                ry_reg   <= dirty.rect_y;
                rw_reg   <= dirty.rect_w;
                rh_reg   <= dirty.rect_h;
                last_reg <= dirty.frame_end;
            end

            // candidate preparation
            if (state_reg == S_CLAMP)
            begin
                cand_reg <= clamped;
            end
            if (state_reg == S_GROW)
            begin
                cand_reg <= grown;
            end
            if (state_reg == S_AREA)
            begin
                area_reg <= cand_prod[AREA_W-1:0];
            end

            // table fill and drain
            if (any_append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (emit_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end

            // output register
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                out_rect_reg  <= ent[0].rect;
                out_last_reg  <= (count_reg == CNT_W'(1));
            end
            else if (merged.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dirty.ready     = (state_reg == S_IDLE);
    assign merged.valid    = out_valid_reg;
    assign merged.left     = out_rect_reg.l;
    assign merged.top      = out_rect_reg.t;
    assign merged.right    = out_rect_reg.r;
    assign merged.bottom   = out_rect_reg.b;
    assign merged.last_out = out_last_reg;

`ifndef SYNTHESIS
    // at most one cell takes a candidate
    a_one_taker: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("more than one cell took the candidate");

    // the table never holds more entries than cells
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECTS))
        else $error("rectangle count above table size");

    // appends only land in a table that has room
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        any_append |-> (count_reg < CNT_W'(MAX_RECTS)))
        else $error("append into a full table");

    // each emitted word drains exactly one entry
    a_emit_drain: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("emission did not drain one entry");

    // the candidate never falls off the end of the row
    a_no_escape: assert property (@(posedge clk) disable iff (!rst_n) !tok[MAX_RECTS].valid)
        else $error("candidate passed the last cell");
`endif

endmodule

`default_nettype wire
